@@ hw/rtl/fcms_pkg.sv @@
// Shared types and operation codes for the fixed-capacity multiset store.
package fcms_pkg;

  localparam logic [1:0] MODE_ADD    = 2'd0;
  localparam logic [1:0] MODE_REMOVE = 2'd1;
  localparam logic [1:0] MODE_QUERY  = 2'd2;
  localparam logic [1:0] MODE_CLEAR  = 2'd3;

  localparam int COUNT_OUT_W = 5;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_MOVE
  } state_t;

endpackage

@@ hw/rtl/fcms_mem.sv @@
// Entry store: single-port-write, registered-read memory.
module fcms_mem #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 32,
  parameter int AW    = 4
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

@@ hw/rtl/fixed_capacity_multiset_store_top.sv @@
// Fixed-capacity multiset store: sequencer over a packed entry memory.
// Add, clear, and remove or query on an empty store: done is high in the cycle after start.
// Query on n entries: done follows a scan of all n entries; remove: the scan stops at the first match.
// One memory read per cycle sets the scan length, which is at most CAPACITY entries.
// A new item is taken in the cycle done is high; results cannot be stalled.
// Synchronous reset empties the store and returns the sequencer to idle.
module fixed_capacity_multiset_store_top #(
  parameter int CAPACITY    = 16,
  parameter int VALUE_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  mode,
  input  logic [31:0] item_value,
  output logic        done,
  output logic        success,
  output logic [4:0]  match_count,
  output logic [4:0]  current_size,
  output logic        is_empty
);

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);
  localparam logic [CW-1:0] CAP_CNT = CW'(CAPACITY);

  fcms_pkg::state_t state, state_next;

  logic [1:0]             op_mode;
  logic [VALUE_WIDTH-1:0] op_value;
  logic [CW-1:0]          count, count_next;
  logic [AW-1:0]          scan_idx;
  logic [AW-1:0]          pos;
  logic [CW-1:0]          hits;

  logic                   accept;
  logic [VALUE_WIDTH-1:0] in_value;
  logic [CW-1:0]          last_idx;
  logic                   at_last;
  logic                   hit;
  logic [CW-1:0]          hits_final;

  logic                   wr_en;
  logic [AW-1:0]          wr_addr;
  logic [VALUE_WIDTH-1:0] wr_data;
  logic [AW-1:0]          rd_addr;
  logic [VALUE_WIDTH-1:0] rd_data;

  logic                   res_load;
  logic                   res_ok;
  logic [CW-1:0]          res_hits;
  logic [CW-1:0]          res_size;

  assign busy       = (state != fcms_pkg::ST_IDLE);
  assign accept     = start && !busy;
  assign in_value   = VALUE_WIDTH'(item_value);
  assign last_idx   = count - CW'(1);
  assign at_last    = (CW'(scan_idx) == last_idx);
  assign hit        = (rd_data == op_value);
  assign hits_final = hit ? (hits + CW'(1)) : hits;

  fcms_mem #(
    .DEPTH (CAPACITY),
    .WIDTH (VALUE_WIDTH),
    .AW    (AW)
  ) u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      fcms_pkg::ST_IDLE: begin
        if (accept && (mode == fcms_pkg::MODE_REMOVE || mode == fcms_pkg::MODE_QUERY)
            && count != '0) begin
          state_next = fcms_pkg::ST_SCAN;
        end
      end
      fcms_pkg::ST_SCAN: begin
        if (op_mode == fcms_pkg::MODE_REMOVE && hit) begin
          state_next = at_last ? fcms_pkg::ST_IDLE : fcms_pkg::ST_MOVE;
        end else if (at_last) begin
          state_next = fcms_pkg::ST_IDLE;
        end
      end
      fcms_pkg::ST_MOVE: begin
        state_next = fcms_pkg::ST_IDLE;
      end
      default: begin
        state_next = fcms_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    rd_addr    = '0;
    wr_en      = 1'b0;
    wr_addr    = AW'(count);
    wr_data    = in_value;
    count_next = count;
    res_load   = 1'b0;
    res_ok     = 1'b0;
    res_hits   = '0;
    res_size   = count;
    unique case (state)
      fcms_pkg::ST_IDLE: begin
        if (accept) begin
          unique case (mode)
            fcms_pkg::MODE_ADD: begin
              res_load = 1'b1;
              if (count < CAP_CNT) begin
                wr_en      = 1'b1;
                count_next = count + CW'(1);
                res_ok     = 1'b1;
                res_size   = count + CW'(1);
              end
            end
            fcms_pkg::MODE_CLEAR: begin
              count_next = '0;
              res_load   = 1'b1;
              res_ok     = 1'b1;
              res_size   = '0;
            end
            fcms_pkg::MODE_REMOVE, fcms_pkg::MODE_QUERY: begin
              res_load = (count == '0);
            end
            default: begin
              res_load = 1'b0;
            end
          endcase
        end
      end
      fcms_pkg::ST_SCAN: begin
        rd_addr = scan_idx + AW'(1);
        if (op_mode == fcms_pkg::MODE_REMOVE) begin
          if (hit) begin
            rd_addr    = AW'(last_idx);
            count_next = last_idx;
            if (at_last) begin
              res_load = 1'b1;
              res_ok   = 1'b1;
              res_size = last_idx;
            end
          end else if (at_last) begin
            res_load = 1'b1;
          end
        end else if (at_last) begin
          res_load = 1'b1;
          res_ok   = (hits_final != '0);
          res_hits = hits_final;
        end
      end
      fcms_pkg::ST_MOVE: begin
        wr_en    = 1'b1;
        wr_addr  = pos;
        wr_data  = rd_data;
        res_load = 1'b1;
        res_ok   = 1'b1;
      end
      default: begin
        res_load = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= fcms_pkg::ST_IDLE;
      count <= '0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      done  <= res_load;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_mode  <= mode;
      op_value <= in_value;
      scan_idx <= '0;
      hits     <= '0;
    end else if (state == fcms_pkg::ST_SCAN) begin
      scan_idx <= scan_idx + AW'(1);
      hits     <= hits_final;
      if (hit) begin
        pos <= scan_idx;
      end
    end
    if (res_load) begin
      success      <= res_ok;
      match_count  <= fcms_pkg::COUNT_OUT_W'(res_hits);
      current_size <= fcms_pkg::COUNT_OUT_W'(res_size);
      is_empty     <= (res_size == '0);
    end
  end

endmodule

@@ hw/rtl/fcms_checker.sv @@
// Port-level checker for the multiset store, bound to the top level.
module fcms_checker (
  input logic       clk,
  input logic       rst,
  input logic       start,
  input logic       busy,
  input logic [1:0] mode,
  input logic       done,
  input logic       success,
  input logic [4:0] match_count,
  input logic [4:0] current_size,
  input logic       is_empty
);

  a_reset_idle: assert property (@(posedge clk) rst |=> !busy && !done)
    else $error("not idle after reset");

  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("result while busy");

  a_accept_progress: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy || done)
    else $error("accepted item neither worked on nor finished");

  a_clear_result: assert property (@(posedge clk) disable iff (rst)
    start && !busy && mode == fcms_pkg::MODE_CLEAR |=>
      done && success && is_empty && current_size == 5'd0)
    else $error("clear result wrong");

  a_match_success: assert property (@(posedge clk) disable iff (rst)
    done && match_count != 5'd0 |-> success)
    else $error("matches reported without success");

endmodule

bind fixed_capacity_multiset_store_top fcms_checker u_fcms_checker (.*);
